@@ rtl/skht_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted key handler table package
// Shared sizes, beat structures, status codes and the control and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skht_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int HANDLER_BITS = 16;
    localparam int SIG_BITS     = 8;
    localparam int KEY_BITS     = 64;
    localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } command_t;

    typedef struct packed {
        command_t                command;
        logic [KEY_BITS-1:0]     key;
        logic [HANDLER_BITS-1:0] handler;
        logic                    handler_present;
        logic [SIG_BITS-1:0]     signature;
    } in_item_t;

    typedef struct packed {
        status_t                 status;
        logic [HANDLER_BITS-1:0] handler_out;
        logic [SIG_BITS-1:0]     signature_out;
        logic                    callable;
        logic [CNT_BITS-1:0]     entry_count;
    } result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [HANDLER_BITS-1:0] handler;
        logic [SIG_BITS-1:0]     signature;
        logic                    present;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    rd_mid;
        logic    upd_bound;
        logic    rd_pos;
        logic    rd_shift;
        logic    wr_shift;
        logic    wr_new;
        logic    inc_count;
        logic    set_result;
        status_t res_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic     range_empty;
        logic     key_hit;
        logic     full;
        logic     shift_done;
        command_t command;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/skht_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted key handler table controller
// Sequences the lower-bound search, the hit check, the upward shift of the
// later entries and the write of a new or replaced entry.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire skht_pkg::dp_status_t stat,
    output skht_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SEARCH   = 7'b0000010,
        S_COMPARE  = 7'b0000100,
        S_CHECK    = 7'b0001000,
        S_MATCH    = 7'b0010000,
        S_SHIFT    = 7'b0100000,
        S_SHIFT_WR = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.rd_mid     = 1'b0;
        cmd.upd_bound  = 1'b0;
        cmd.rd_pos     = 1'b0;
        cmd.rd_shift   = 1'b0;
        cmd.wr_shift   = 1'b0;
        cmd.wr_new     = 1'b0;
        cmd.inc_count  = 1'b0;
        cmd.set_result = 1'b0;
        cmd.res_status = skht_pkg::ST_INSERTED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.range_empty)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.upd_bound = 1'b1;
                state_next    = S_SEARCH;
            end
            S_CHECK:
            begin
                cmd.rd_pos = 1'b1;
                state_next = S_MATCH;
            end
            S_MATCH:
            begin
                if (stat.command == skht_pkg::CMD_LOOKUP)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = stat.key_hit ? skht_pkg::ST_FOUND
                                                  : skht_pkg::ST_MISSING;
                    state_next     = S_IDLE;
                end
                else if (stat.key_hit)
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.res_status = skht_pkg::ST_REPLACED;
                    state_next     = S_IDLE;
                end
                else if (stat.full)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = skht_pkg::ST_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    cmd.wr_new     = 1'b1;
                    cmd.inc_count  = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.res_status = skht_pkg::ST_INSERTED;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHIFT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/skht_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorted key handler table datapath
// Holds the entry memory, the search bounds, the shift pointer, the entry
// count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire skht_pkg::in_item_t   item,
    input  wire skht_pkg::ctrl_cmd_t  cmd,
    output skht_pkg::dp_status_t      stat,
    output logic                      done,
    output skht_pkg::result_t         result
);

    localparam int IW = skht_pkg::IDX_BITS;
    localparam int CW = skht_pkg::CNT_BITS;

    skht_pkg::entry_t mem [skht_pkg::TABLE_DEPTH];
    skht_pkg::entry_t rdata_reg;

    skht_pkg::in_item_t item_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] mid_reg;
    logic [CW-1:0] sh_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;

    skht_pkg::status_t             res_status_reg;
    logic [skht_pkg::HANDLER_BITS-1:0] res_handler_reg;
    logic [skht_pkg::SIG_BITS-1:0]     res_sig_reg;
    logic                              res_call_reg;

    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid_val;
    logic [CW-1:0]    sh_prev;
    logic [IW-1:0]    raddr;
    logic [IW-1:0]    waddr;
    logic             rd_en;
    logic             wr_en;
    skht_pkg::entry_t wdata;
    skht_pkg::entry_t new_entry;
    logic             pos_in_range;
    logic             found;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_val  = mid_sum[CW:1];
    assign sh_prev  = sh_reg - CW'(1);

    assign new_entry.key       = item_reg.key;
    assign new_entry.handler   = item_reg.handler;
    assign new_entry.signature = item_reg.signature;
    assign new_entry.present   = item_reg.handler_present;

    always_comb
    begin
        raddr = lo_reg[IW-1:0];
        if (cmd.rd_mid)
        begin
            raddr = mid_val[IW-1:0];
        end
        else if (cmd.rd_shift)
        begin
            raddr = sh_prev[IW-1:0];
        end
    end

    assign pos_in_range = (lo_reg < count_reg);
    assign rd_en = cmd.rd_mid | cmd.rd_shift | (cmd.rd_pos & pos_in_range);
    assign wr_en = cmd.wr_new | cmd.wr_shift;
    assign waddr = cmd.wr_shift ? sh_reg[IW-1:0] : lo_reg[IW-1:0];
    assign wdata = cmd.wr_shift ? rdata_reg : new_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            lo_reg   <= '0;
            hi_reg   <= count_reg;
            sh_reg   <= count_reg;
        end
        else
        begin
            if (cmd.rd_mid)
            begin
                mid_reg <= mid_val;
            end
            if (cmd.upd_bound)
            begin
                if (rdata_reg.key < item_reg.key)
                begin
                    lo_reg <= mid_reg + CW'(1);
                end
                else
                begin
                    hi_reg <= mid_reg;
                end
            end
            if (cmd.wr_shift)
            begin
                sh_reg <= sh_prev;
            end
        end
    end

    assign count_next = cmd.inc_count ? count_reg + CW'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.set_result;
        end
    end

    assign found = (cmd.res_status == skht_pkg::ST_FOUND);

    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            res_status_reg  <= cmd.res_status;
            res_handler_reg <= found ? rdata_reg.handler : '0;
            res_sig_reg     <= found ? rdata_reg.signature : '0;
            res_call_reg    <= found & rdata_reg.present;
        end
    end

    assign stat.range_empty = !(lo_reg < hi_reg);
    assign stat.key_hit     = pos_in_range && (rdata_reg.key == item_reg.key);
    assign stat.full        = (count_reg == CW'(skht_pkg::TABLE_DEPTH));
    assign stat.shift_done  = (sh_reg == lo_reg);
    assign stat.command     = item_reg.command;

    assign done                 = done_reg;
    assign result.status        = res_status_reg;
    assign result.handler_out   = res_handler_reg;
    assign result.signature_out = res_sig_reg;
    assign result.callable      = res_call_reg;
    assign result.entry_count   = count_reg;

endmodule

`default_nettype wire

@@ rtl/sorted_key_handler_table.sv @@
// A lookup runs S lower-bound search steps, S being at most ceil(log2(count + 1)), then
// reads the entry at the bound and checks it for a hit before the done strobe.
// An insert of a new key also moves every later entry up by one place before the new entry is written.
// The next beat is accepted in the cycle that shows the result; the memory has one read port and one write port.
// Reset clears the entry count and the controller; the table contents are not cleared.
// ----------------------------------------------------------------------------
// Sorted key handler table
// A table kept in ascending key order, searched by lower bound, with
// in-place replacement and ordered insertion of handler entries.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_handler_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire skht_pkg::in_item_t item,
    output logic                    done,
    output skht_pkg::result_t       result
);

    skht_pkg::ctrl_cmd_t  cmd;
    skht_pkg::dp_status_t stat;

    skht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    skht_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.entry_count <= skht_pkg::CNT_BITS'(skht_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == skht_pkg::ST_INSERTED)
        |-> result.entry_count == $past(result.entry_count) + skht_pkg::CNT_BITS'(1))
        else $error("insert did not grow the entry count by one");
`endif

endmodule

`default_nettype wire
